>>> src/tmrm_pkg.sv
// Shared constants for the running mex block.
package tmrm_pkg;

    // Field widths.
    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 20;
    localparam int VAL_W    = 11;
    localparam int CNT_W    = 11;

    // Count store: one slot per value 0..1025.
    localparam int VALUE_SLOTS = 1026;

    // Weights above this cap are never counted; the mex never passes its top.
    localparam logic [VAL_W-1:0] VALUE_CAP = 11'd1024;
    localparam logic [VAL_W-1:0] MEX_TOP   = 11'd1025;
    localparam logic [VAL_W-1:0] LAST_SLOT = 11'd1025;
    localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

    // Operation codes.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_TOGGLE = 1'b1;

endpackage

>>> src/tmrm_ram.sv
// Simple dual-port synchronous memory with a registered read.
module tmrm_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // One write and one read per cycle; a read of the address written returns old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/toggle_multiset_running_mex_top.sv
// Top level of the running mex block: control sequencer, node store and count store.
//
//  Channel  | Direction | Handshake             | Word
//  ---------+-----------+-----------------------+-------------------------------------
//  input    | in        | i_valid / o_stall     | i_operation, i_node, i_weight
//  result   | out       | o_valid / i_stall     | o_mex
//  config   | in        | i_cfg_wr_en           | i_cfg_wr_data (max_value)
//
// A load reads its node entry and writes it back; a node out of range skips both memories.
// A toggle above max_value does the same; an exit also updates its count, and an entry
// updates its count and then scans the mex upward, one count read per step, unless the mex
// is at its top. After reset a clearing pass zeroes both memories; no word is taken then.
// A finished word waits in the output register while the next word is accepted; a word that
// is done while that register is still stalled holds the block until it frees.
module toggle_multiset_running_mex_top
    import tmrm_pkg::*;
#(
    parameter int NODES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_operation,
    input  logic [NODE_W-1:0]   i_node,
    input  logic [WEIGHT_W-1:0] i_weight,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [VAL_W-1:0]    o_mex,
    input  logic                i_cfg_wr_en,
    input  logic [VAL_W-1:0]    i_cfg_wr_data
);

    localparam int NODE_DEPTH = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);
    localparam int NODE_AW    = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
    localparam int NWORD_W    = WEIGHT_W + 1;
    localparam int CNT_AW     = $clog2(VALUE_SLOTS);
    localparam logic [NODE_W:0] NODE_LIM = (NODE_W+1)'(NODE_DEPTH);
    localparam logic [CNT_AW-1:0] CLR_NODE_LIM = CNT_AW'(NODE_DEPTH);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_NODE  = 3'd2;
    localparam logic [2:0] ST_COUNT = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [CNT_AW-1:0]   r_clr_cnt, n_clr_cnt;
    logic [VAL_W-1:0]    r_max_value;
    logic [VAL_W-1:0]    r_mex, n_mex;
    logic                r_op, n_op;
    logic [NODE_AW-1:0]  r_node, n_node;
    logic [WEIGHT_W-1:0] r_weight, n_weight;
    logic [CNT_AW-1:0]   r_cnt_addr, n_cnt_addr;
    logic                r_enter, n_enter;
    logic                r_fwd, n_fwd;
    logic [CNT_W-1:0]    r_fwd_data, n_fwd_data;
    logic                r_out_valid, n_out_valid;
    logic [VAL_W-1:0]    r_out_mex, n_out_mex;

    // Memory port signals.
    logic                node_we;
    logic [NODE_AW-1:0]  node_waddr, node_raddr;
    logic [NWORD_W-1:0]  node_wdata, node_rdata;
    logic                cnt_we;
    logic [CNT_AW-1:0]   cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;

    // Working values.
    logic                accept;
    logic                in_range;
    logic [VAL_W-1:0]    limit;
    logic                node_present;
    logic [WEIGHT_W-1:0] node_weight;
    logic [CNT_W-1:0]    cnt_new;
    logic [CNT_W-1:0]    cnt_seen;
    logic [VAL_W-1:0]    mex_inc;
    logic                out_free;

    // Node store: {present, weight} per node.
    tmrm_ram #(
        .W     (NWORD_W),
        .DEPTH (NODE_DEPTH),
        .AW    (NODE_AW)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    // Count store: one count per value.
    tmrm_ram #(
        .W     (CNT_W),
        .DEPTH (VALUE_SLOTS),
        .AW    (CNT_AW)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && (r_state == ST_IDLE);
    assign in_range = ({1'b0, i_node} < NODE_LIM);
    assign limit    = (r_max_value > VALUE_CAP) ? VALUE_CAP : r_max_value;
    assign node_present = node_rdata[WEIGHT_W];
    assign node_weight  = node_rdata[WEIGHT_W-1:0];
    assign mex_inc  = r_mex + 11'd1;
    assign cnt_seen = r_fwd ? r_fwd_data : cnt_rdata;
    assign out_free = !r_out_valid || !i_stall;

    // New count after an entry saturates, after an exit stops at zero.
    always_comb begin
        if (r_enter) begin
            cnt_new = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + 11'd1;
        end else begin
            cnt_new = (cnt_rdata == '0) ? cnt_rdata : cnt_rdata - 11'd1;
        end
    end

    // Sequencer and memory port control.
    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_mex       = r_mex;
        n_op        = r_op;
        n_node      = r_node;
        n_weight    = r_weight;
        n_cnt_addr  = r_cnt_addr;
        n_enter     = r_enter;
        n_fwd       = 1'b0;
        n_fwd_data  = r_fwd_data;
        n_out_valid = r_out_valid && i_stall;
        n_out_mex   = r_out_mex;

        node_we    = 1'b0;
        node_waddr = r_node;
        node_wdata = {(r_op == OP_TOGGLE) ? !node_present : node_present,
                      (r_op == OP_TOGGLE) ? node_weight : r_weight};
        node_raddr = i_node[NODE_AW-1:0];
        cnt_we     = 1'b0;
        cnt_waddr  = r_cnt_addr;
        cnt_wdata  = cnt_new;
        cnt_raddr  = r_cnt_addr;

        unique case (r_state)
            ST_CLEAR: begin
                // Zero one count and, within the node depth, one node entry per cycle.
                cnt_we     = 1'b1;
                cnt_waddr  = r_clr_cnt;
                cnt_wdata  = '0;
                node_we    = (r_clr_cnt < CLR_NODE_LIM);
                node_waddr = r_clr_cnt[NODE_AW-1:0];
                node_wdata = '0;
                n_clr_cnt  = r_clr_cnt + 1'b1;
                if (r_clr_cnt == LAST_SLOT) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_op     = i_operation;
                    n_node   = i_node[NODE_AW-1:0];
                    n_weight = i_weight;
                    n_state  = in_range ? ST_NODE : ST_DONE;
                end
            end
            ST_NODE: begin
                // Node entry is here; write it back and, for a toggle within the limit, start the count access.
                node_we = 1'b1;
                n_state = ST_DONE;
                if (r_op == OP_TOGGLE && {9'd0, limit} >= node_weight) begin
                    n_cnt_addr = node_weight[CNT_AW-1:0];
                    cnt_raddr  = node_weight[CNT_AW-1:0];
                    n_enter    = !node_present;
                    n_state    = ST_COUNT;
                end
            end
            ST_COUNT: begin
                // Count is here; write it back.
                cnt_we = 1'b1;
                if (r_enter) begin
                    cnt_raddr  = r_mex[CNT_AW-1:0];
                    n_fwd      = (r_cnt_addr == r_mex[CNT_AW-1:0]);
                    n_fwd_data = cnt_new;
                    n_state    = (r_mex == MEX_TOP) ? ST_DONE : ST_SCAN;
                end else begin
                    if (cnt_new == '0 && {1'b0, r_cnt_addr} < {1'b0, r_mex}) begin
                        n_mex = VAL_W'(r_cnt_addr);
                    end
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                // Step the mex past nonzero counts, one read per cycle.
                cnt_raddr = mex_inc[CNT_AW-1:0];
                if (r_mex != MEX_TOP && cnt_seen != '0) begin
                    n_mex = mex_inc;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_mex   = r_mex;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_mex       <= '0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_mex       <= n_mex;
            r_fwd       <= n_fwd;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value <= VALUE_CAP;
        end else if (i_cfg_wr_en) begin
            r_max_value <= i_cfg_wr_data;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_node     <= n_node;
        r_weight   <= n_weight;
        r_cnt_addr <= n_cnt_addr;
        r_enter    <= n_enter;
        r_fwd_data <= n_fwd_data;
        r_out_mex  <= n_out_mex;
    end

    assign o_valid = r_out_valid;
    assign o_mex   = r_out_mex;

endmodule
